### hdl/ftm_pkg.sv
// Package for the triangle membership block: widths, register codes, shared tag type.
// No dependencies.
package ftm_pkg;

    localparam int MAX_SETS_DEF    = 7;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int Q_BITS          = 16;
    localparam int ONE_Q15         = 32768;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 32;
    localparam int SET_BITS        = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_SETS  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SET_BOUNDS_0 = 3'd1;

    typedef struct packed {
        logic                last;
        logic [SET_BITS-1:0] idx;
    } ftm_tag_t;

endpackage

### hdl/ftm_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ftm_pkg.
module ftm_divider
    import ftm_pkg::*;
#(
    parameter int NUM_BITS = 18,
    parameter int DEN_BITS = 19,
    parameter int Q_OUT    = 16,
    parameter int TAG_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    input  logic [TAG_BITS-1:0] tag_in,
    output logic                out_valid,
    output logic [Q_OUT-1:0]    quo,
    output logic [TAG_BITS-1:0] tag_out
);
    // quo = floor(num * 2^(Q_OUT-1) / den), exact while num < 2*den
    localparam int RW = DEN_BITS + 1;

    logic [Q_OUT:1]              v_reg;
    logic [RW-1:0]               rem_reg [1:Q_OUT];
    logic [DEN_BITS-1:0]         d_reg   [1:Q_OUT];
    logic [Q_OUT-1:0]            q_reg   [1:Q_OUT];
    logic [TAG_BITS-1:0]         t_reg   [1:Q_OUT];

    for (genvar s = 0; s < Q_OUT; s++)
    begin : g_stage
        logic                v_in;
        logic [RW-1:0]       rem_in;
        logic                n_bit;
        logic [DEN_BITS-1:0] d_in;
        logic [Q_OUT-1:0]    q_in;
        logic [TAG_BITS-1:0] t_in;
        logic [RW:0]         trial;
        logic [RW:0]         diff;

        if (s == 0)
        begin : g_first
            // upper numerator bits preload the remainder; the lowest one enters here
            assign v_in   = in_valid;
            assign rem_in = RW'(num[NUM_BITS-1:1]);
            assign n_bit  = num[0];
            assign d_in   = den;
            assign q_in   = '0;
            assign t_in   = tag_in;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[s];
            assign rem_in = rem_reg[s];
            assign n_bit  = 1'b0;
            assign d_in   = d_reg[s];
            assign q_in   = q_reg[s];
            assign t_in   = t_reg[s];
        end

        assign trial = {rem_in, n_bit};
        assign diff  = trial - {2'b00, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            d_reg[s+1] <= d_in;
            t_reg[s+1] <= t_in;
            if (!diff[RW])
            begin
                rem_reg[s+1] <= diff[RW-1:0];
                q_reg[s+1]   <= {q_in[Q_OUT-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= trial[RW-1:0];
                q_reg[s+1]   <= {q_in[Q_OUT-2:0], 1'b0};
            end
        end
    end

    assign out_valid = v_reg[Q_OUT];
    assign quo       = q_reg[Q_OUT];
    assign tag_out   = t_reg[Q_OUT];
endmodule

### hdl/fuzzy_triangle_membership.sv
// Top level: config registers, serializer, membership and normalization dividers.
// Depends on ftm_pkg and ftm_divider.
//
// channel  | ports                                            | dir
// config   | cfg_we, cfg_index, cfg_data                      | in
// sample   | start, busy, sample                              | in, busy out
// result   | result_valid, set_index, membership, normalized, | out
//          | sum_zero, last                                   |
// One result per active set per cycle; the serializer steps through a sample's
// active sets (busy high for all but the first). The first result word passes the
// operand stage, 16-stage membership divider, wait for the sample's last set to
// close the sum, bank load and 16-stage normalize divider. Later words follow one
// per cycle.
// Reset clears config and all valid bits. Results cannot be stalled.
module fuzzy_triangle_membership
    import ftm_pkg::*;
#(
    parameter int MAX_SETS    = MAX_SETS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     start,
    output logic                     busy,
    input  logic [SAMPLE_BITS-1:0]   sample,
    output logic                     result_valid,
    output logic [SET_BITS-1:0]      set_index,
    output logic [Q_BITS-1:0]        membership,
    output logic [Q_BITS-1:0]        normalized,
    output logic                     sum_zero,
    output logic                     last
);
    localparam int QO = 16;
    localparam int MT = SET_BITS + 1 + 1 + 1;

    logic [SET_BITS-1:0] active_reg;
    logic [31:0]         bounds_reg [MAX_SETS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int k = 0; k < MAX_SETS; k++)
                bounds_reg[k] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ACTIVE_SETS)
                active_reg <= cfg_data[SET_BITS-1:0];
            else if (32'(cfg_index) <= 32'(MAX_SETS))
                bounds_reg[cfg_index - REG_SET_BOUNDS_0] <= cfg_data;
        end
    end

    logic [SET_BITS-1:0] count;
    assign count = (32'(active_reg) > 32'(MAX_SETS)) ? SET_BITS'(MAX_SETS) : active_reg;

    // serializer
    logic                   run_reg;
    logic [SET_BITS-1:0]    k_reg;
    logic [15:0]            x_reg;
    logic                   go;
    logic [SET_BITS-1:0]    cur_k;
    logic [15:0]            cur_x;
    logic                   cur_last;

    assign busy     = run_reg;
    assign go       = run_reg || (start && count != '0);
    assign cur_k    = run_reg ? k_reg : '0;
    assign cur_x    = run_reg ? x_reg : 16'(sample);
    assign cur_last = (cur_k + 3'd1) == count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            k_reg   <= '0;
        end
        else if (go)
        begin
            run_reg <= !cur_last;
            k_reg   <= cur_k + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!run_reg)
            x_reg <= 16'(sample);
    end

    // stage 1: bounds compare and operands
    logic [15:0] lo, hi;
    logic [16:0] span, d, lohi, x2;
    logic        in_range, degen;
    assign lo       = bounds_reg[cur_k][15:0];
    assign hi       = bounds_reg[cur_k][31:16];
    assign in_range = (cur_x >= lo) && (cur_x <= hi);
    assign span     = {1'b0, hi} - {1'b0, lo};
    assign degen    = (hi == lo);
    assign lohi     = {1'b0, lo} + {1'b0, hi};
    assign x2       = {cur_x, 1'b0};
    assign d        = (x2 <= lohi) ? ({1'b0, cur_x} - {1'b0, lo})
                                   : ({1'b0, hi} - {1'b0, cur_x});

    logic                v1_reg;
    logic [17:0]         num1_reg;
    logic [18:0]         den1_reg;
    ftm_tag_t            tag1_reg;
    logic                in1_reg, dg1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= go;
    end

    always_ff @(posedge clk)
    begin
        num1_reg <= {d, 1'b0};
        den1_reg <= {2'b00, span};
        tag1_reg <= '{last: cur_last, idx: cur_k};
        in1_reg  <= in_range;
        dg1_reg  <= degen;
    end

    // membership = 2d*32768/span; 2d <= span keeps it within 16 bits
    logic          v2;
    logic [QO-1:0] q2;
    logic [MT-1:0] t2;

    ftm_divider #(.NUM_BITS(18), .DEN_BITS(19), .Q_OUT(QO), .TAG_BITS(MT)) u_mu_div
    (
        .clk(clk), .rst_n(rst_n), .in_valid(v1_reg),
        .num(num1_reg), .den(dg1_reg ? 19'd1 : den1_reg),
        .tag_in({in1_reg, dg1_reg, tag1_reg}),
        .out_valid(v2), .quo(q2), .tag_out(t2)
    );

    logic [15:0] mu2;
    always_comb
    begin
        if (!t2[MT-1])
            mu2 = '0;
        else if (t2[MT-2])
            mu2 = 16'(ONE_Q15);
        else
            mu2 = q2;
    end

    // sum accumulation per sample
    logic [18:0] acc_reg;
    logic [18:0] acc_next;
    assign acc_next = acc_reg + 19'(mu2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (v2)
            acc_reg <= t2[SET_BITS] ? '0 : acc_next;
    end

    // holding buffer: results of one sample wait until its sum is known
    logic [15:0]         buf_mu  [MAX_SETS];
    logic [SET_BITS-1:0] rd_reg;
    logic [SET_BITS-1:0] rcnt_reg;
    logic [18:0]         sum_reg;
    logic                drain_reg;

    always_ff @(posedge clk)
    begin
        if (v2)
            buf_mu[t2[SET_BITS-1:0]] <= mu2;
    end

    // drain uses a second bank so a new sample can fill while the previous drains
    logic [15:0]         bank_mu [MAX_SETS];
    logic                dv;
    logic [15:0]         dmu;
    ftm_tag_t            dtag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            rd_reg    <= '0;
            rcnt_reg  <= '0;
        end
        else
        begin
            if (v2 && t2[SET_BITS])
            begin
                drain_reg <= 1'b1;
                rd_reg    <= '0;
                rcnt_reg  <= t2[SET_BITS-1:0];
            end
            else if (drain_reg && rd_reg == rcnt_reg)
                drain_reg <= 1'b0;
            else if (drain_reg)
                rd_reg <= rd_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2 && t2[SET_BITS])
        begin
            sum_reg <= acc_next;
            for (int k = 0; k < MAX_SETS; k++)
                bank_mu[k] <= (k == int'(t2[SET_BITS-1:0])) ? mu2 : buf_mu[k];
        end
    end

    assign dv   = drain_reg;
    assign dmu  = bank_mu[rd_reg];
    assign dtag = '{last: rd_reg == rcnt_reg, idx: rd_reg};

    logic          v5;
    logic [QO-1:0] q5;
    logic [16+SET_BITS+2-1:0] t5;

    ftm_divider #(.NUM_BITS(16), .DEN_BITS(19), .Q_OUT(QO),
                  .TAG_BITS(16+SET_BITS+2)) u_norm_div
    (
        .clk(clk), .rst_n(rst_n), .in_valid(dv),
        .num(dmu), .den((sum_reg == '0) ? 19'd1 : sum_reg),
        .tag_in({dmu, sum_reg == '0, dtag}),
        .out_valid(v5), .quo(q5), .tag_out(t5)
    );

    assign result_valid = v5;
    assign set_index    = t5[SET_BITS-1:0];
    assign last         = t5[SET_BITS];
    assign sum_zero     = t5[SET_BITS+1];
    assign membership   = t5[SET_BITS+17:SET_BITS+2];
    assign normalized   = t5[SET_BITS+1] ? 16'd0 : q5;
endmodule
